>>> hw/rtl/tc2us_pkg.sv
// Shared types and constants for the tick-count to microsecond converter.
// No dependencies; used by tick_count_to_microseconds.
package tc2us_pkg;

    localparam int unsigned READING_W = 32;
    localparam int unsigned TOTAL_W   = 64;
    localparam int unsigned FRAC_W    = 20;   // fraction of a second in us, < 10^6
    localparam int unsigned PROD_W    = READING_W + FRAC_W;   // remainder * 10^6
    localparam int unsigned SECS_W    = TOTAL_W + 1;          // seconds + 1
    localparam int unsigned ACC_W     = SECS_W + FRAC_W;      // (seconds + 1) * 10^6
    localparam int unsigned CNT_W     = 6;

    localparam logic [READING_W-1:0] DEFAULT_TICK_RATE = 32'd709379;
    localparam logic [FRAC_W-1:0]    US_PER_SECOND     = 20'd1000000;

    // last value of the step counter for each serial pass
    localparam logic [CNT_W-1:0] SEC_DIV_LAST  = 6'(TOTAL_W - 1);
    localparam logic [CNT_W-1:0] FRAC_DIV_LAST = 6'(PROD_W - 1);
    localparam logic [CNT_W-1:0] MUL_LAST      = 6'(FRAC_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SEC,
        ST_MUL_REM,
        ST_DIV_FRAC,
        ST_MUL_SEC,
        ST_SUM
    } state_t;

endpackage

>>> hw/rtl/tick_count_to_microseconds.sv
// Top level: 32-bit tick counter readings to a saturating 64-bit microsecond timestamp.
// Depends on tc2us_pkg (types, widths, constants).
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | in_valid / in_ready    | counter_reading[31:0], is_first
//  output   | out_valid / out_ready  | elapsed_us[63:0]
//  config   | cfg_wr_en (no wait)    | cfg_wr_data[31:0] -> tick_rate
//
// One item in flight. An input beat is taken in IDLE; the seconds division,
// remainder multiply, fraction division, seconds multiply and final add follow in
// that order, and the next beat can be taken once the block is back in IDLE. The
// seconds and the fraction share the bit-serial restoring divider (64 steps for
// seconds, 52 for the fraction); the seconds multiply by 10^6 is bit-serial (20 steps).
// Reset (rst_n low, async) clears the counter state and loads the default rate.
// A result waits in the output register; the block takes the next input
// beat meanwhile, and only stalls in its final add if the old result is
// still not taken.
module tick_count_to_microseconds
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [tc2us_pkg::READING_W-1:0]   cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tc2us_pkg::READING_W-1:0]   counter_reading,
    input  logic                              is_first,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tc2us_pkg::TOTAL_W-1:0]     elapsed_us
);

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    tc2us_pkg::state_t state_reg, state_next;

    logic [tc2us_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [tc2us_pkg::READING_W-1:0] tick_rate_reg, tick_rate_next;
    logic [tc2us_pkg::READING_W-1:0] rate_eff_reg, rate_eff_next;   // never zero
    logic [tc2us_pkg::READING_W-1:0] prev_reg, prev_next;
    logic [tc2us_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic                            out_valid_reg, out_valid_next;

    // datapath, no reset
    logic [tc2us_pkg::TOTAL_W-1:0]   q_reg, q_next;      // dividend/quotient, multiplier bits
    logic [tc2us_pkg::READING_W-1:0] r_reg, r_next;      // partial remainder
    logic [tc2us_pkg::SECS_W-1:0]    secs_reg, secs_next; // seconds + 1
    logic [tc2us_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [tc2us_pkg::ACC_W-1:0]     acc_reg, acc_next;
    logic [tc2us_pkg::TOTAL_W-1:0]   result_reg, result_next;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic                            in_fire;
    logic                            last_step;
    logic                            out_free;
    logic [tc2us_pkg::READING_W:0]   trial;
    logic [tc2us_pkg::READING_W:0]   trial_diff;
    logic                            trial_ge;
    logic [tc2us_pkg::READING_W-1:0] r_step;
    logic [tc2us_pkg::TOTAL_W-1:0]   q_step;
    logic [tc2us_pkg::PROD_W-1:0]    rem_prod;
    logic [tc2us_pkg::READING_W-1:0] delta;
    logic [tc2us_pkg::ACC_W-1:0]     final_sum;
    logic                            saturate;

    assign in_fire   = in_valid & in_ready;
    assign last_step = (cnt_reg == '0);
    assign out_free  = ~out_valid_reg | out_ready;

    // one restoring-division step: shift in the dividend MSB, try subtract
    assign trial      = {r_reg, q_reg[tc2us_pkg::TOTAL_W-1]};
    assign trial_diff = trial - {1'b0, rate_eff_reg};
    assign trial_ge   = (trial >= {1'b0, rate_eff_reg});
    assign r_step     = trial_ge ? trial_diff[tc2us_pkg::READING_W-1:0]
                                 : trial[tc2us_pkg::READING_W-1:0];
    assign q_step     = {q_reg[tc2us_pkg::TOTAL_W-2:0], trial_ge};

    // remainder * 10^6, 32 x 20 constant multiply
    assign rem_prod = {{tc2us_pkg::FRAC_W{1'b0}}, r_reg}
                    * {{tc2us_pkg::READING_W{1'b0}}, tc2us_pkg::US_PER_SECOND};

    // wrap-safe counter difference
    assign delta = counter_reading - prev_reg;

    // (seconds + 1) * 10^6 + fraction; anything above bit 63 means overflow
    assign final_sum = acc_reg + {{(tc2us_pkg::ACC_W - tc2us_pkg::FRAC_W){1'b0}}, frac_reg};
    assign saturate  = |final_sum[tc2us_pkg::ACC_W-1:tc2us_pkg::TOTAL_W];

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tc2us_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tc2us_pkg::ST_DIV_SEC;
                end
            end
            tc2us_pkg::ST_DIV_SEC:
            begin
                if (last_step)
                begin
                    state_next = tc2us_pkg::ST_MUL_REM;
                end
            end
            tc2us_pkg::ST_MUL_REM:
            begin
                state_next = tc2us_pkg::ST_DIV_FRAC;
            end
            tc2us_pkg::ST_DIV_FRAC:
            begin
                if (last_step)
                begin
                    state_next = tc2us_pkg::ST_MUL_SEC;
                end
            end
            tc2us_pkg::ST_MUL_SEC:
            begin
                if (last_step)
                begin
                    state_next = tc2us_pkg::ST_SUM;
                end
            end
            tc2us_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = tc2us_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tc2us_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs and datapath
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready       = (state_reg == tc2us_pkg::ST_IDLE);
        cnt_next       = cnt_reg;
        tick_rate_next = cfg_wr_en ? cfg_wr_data : tick_rate_reg;
        rate_eff_next  = rate_eff_reg;
        prev_next      = prev_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        q_next         = q_reg;
        r_next         = r_reg;
        secs_next      = secs_reg;
        frac_next      = frac_reg;
        acc_next       = acc_reg;
        result_next    = result_reg;

        case (state_reg)
            tc2us_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    rate_eff_next = (tick_rate_reg == '0) ? tc2us_pkg::DEFAULT_TICK_RATE
                                                          : tick_rate_reg;
                    prev_next     = counter_reading;
                    if (is_first)
                    begin
                        total_next = '0;
                    end
                    else
                    begin
                        total_next = total_reg
                                   + {{(tc2us_pkg::TOTAL_W - tc2us_pkg::READING_W){1'b0}},
                                      delta};
                    end
                    q_next   = total_next;
                    r_next   = '0;
                    cnt_next = tc2us_pkg::SEC_DIV_LAST;
                end
            end
            tc2us_pkg::ST_DIV_SEC:
            begin
                q_next   = q_step;
                r_next   = r_step;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    secs_next = {1'b0, q_step} + 1'b1;
                end
            end
            tc2us_pkg::ST_MUL_REM:
            begin
                q_next   = {rem_prod, {(tc2us_pkg::TOTAL_W - tc2us_pkg::PROD_W){1'b0}}};
                r_next   = '0;
                cnt_next = tc2us_pkg::FRAC_DIV_LAST;
            end
            tc2us_pkg::ST_DIV_FRAC:
            begin
                q_next   = q_step;
                r_next   = r_step;
                cnt_next = cnt_reg - 1'b1;
                if (last_step)
                begin
                    // quotient < 10^6, so its low 20 bits hold it whole
                    frac_next = q_step[tc2us_pkg::FRAC_W-1:0];
                    q_next    = {tc2us_pkg::US_PER_SECOND,
                                 {(tc2us_pkg::TOTAL_W - tc2us_pkg::FRAC_W){1'b0}}};
                    acc_next  = '0;
                    cnt_next  = tc2us_pkg::MUL_LAST;
                end
            end
            tc2us_pkg::ST_MUL_SEC:
            begin
                // Horner over the bits of 10^6, MSB first
                acc_next = {acc_reg[tc2us_pkg::ACC_W-2:0], 1'b0}
                         + (q_reg[tc2us_pkg::TOTAL_W-1]
                            ? {{tc2us_pkg::FRAC_W{1'b0}}, secs_reg}
                            : {tc2us_pkg::ACC_W{1'b0}});
                q_next   = {q_reg[tc2us_pkg::TOTAL_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
            tc2us_pkg::ST_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = saturate ? {tc2us_pkg::TOTAL_W{1'b1}}
                                              : final_sum[tc2us_pkg::TOTAL_W-1:0];
                end
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign elapsed_us = result_reg;

    // ---------------------------------------------------------------
    // Sequential
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tc2us_pkg::ST_IDLE;
            cnt_reg       <= '0;
            tick_rate_reg <= tc2us_pkg::DEFAULT_TICK_RATE;
            rate_eff_reg  <= tc2us_pkg::DEFAULT_TICK_RATE;
            prev_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tick_rate_reg <= tick_rate_next;
            rate_eff_reg  <= rate_eff_next;
            prev_reg      <= prev_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg      <= q_next;
        r_reg      <= r_next;
        secs_reg   <= secs_next;
        frac_reg   <= frac_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == tc2us_pkg::ST_DIV_SEC)
                    && (cnt_reg == tc2us_pkg::SEC_DIV_LAST))
        else $error("accepted beat did not start the seconds division");

    a_rate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rate_eff_reg != '0)
        else $error("effective tick rate is zero");

    a_rem_below_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tc2us_pkg::ST_DIV_SEC || state_reg == tc2us_pkg::ST_DIV_FRAC)
        |-> (r_reg < rate_eff_reg))
        else $error("partial remainder not below divisor");

    a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tc2us_pkg::ST_MUL_SEC || state_reg == tc2us_pkg::ST_SUM)
        |-> (frac_reg < tc2us_pkg::US_PER_SECOND))
        else $error("fraction of a second out of range");

    a_sum_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tc2us_pkg::ST_SUM) && out_valid_reg && !out_ready
        |=> (state_reg == tc2us_pkg::ST_SUM) && out_valid_reg)
        else $error("result overwrote an untaken beat");

endmodule
